>>> hdl/ddl_pkg.sv
// Shared types and constants for the differential drive decel limiter.
`timescale 1ns / 1ps

package ddl_pkg;

  localparam int FRACTION_BITS = 12;
  localparam int DUTY_BITS     = 8;

  localparam int LEVEL_W   = 14;
  localparam int DUTY_W    = 8;
  localparam int DECEL_W   = 16;
  localparam int ELAPSED_W = 16;
  localparam int DELTA_W   = 14;
  localparam int MIX_W     = LEVEL_W + 1;

  localparam int FULL_SCALE = 1 << FRACTION_BITS;
  localparam int DELTA_CAP  = 2 * FULL_SCALE;
  localparam int DUTY_MAX   = (1 << DUTY_BITS) - 1;

  localparam logic [DECEL_W-1:0] DECEL_RESET = 16'd3146;

  typedef enum logic {
    CMD_SET    = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  // Staged input word: mixed targets and step delta already worked out.
  typedef struct packed {
    cmd_t                       cmd;
    logic signed [LEVEL_W-1:0]  left_mix;
    logic signed [LEVEL_W-1:0]  right_mix;
    logic        [DELTA_W-1:0]  delta;
  } stage_word_t;

  // Handshake between the stage register and the result register.
  typedef struct packed {
    logic fire;
    logic fire_update;
  } stage_ctl_t;

endpackage

>>> hdl/ddl_front.sv
// Input stage: decel register, mixer, step delta and the staged word register.
`timescale 1ns / 1ps

module ddl_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [ddl_pkg::LEVEL_W-1:0]  in_forward,
  input  logic signed [ddl_pkg::LEVEL_W-1:0]  in_turn,
  input  logic        [ddl_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  input  logic                                cfg_we,
  input  logic        [ddl_pkg::DECEL_W-1:0]  cfg_wdata,
  input  logic                                slot_free,
  output ddl_pkg::stage_ctl_t                 ctl,
  output ddl_pkg::stage_word_t                word
);

  localparam int MW = ddl_pkg::MIX_W;
  localparam int PW = ddl_pkg::ELAPSED_W + ddl_pkg::DECEL_W;
  localparam logic signed [MW-1:0] MIX_MAX = MW'(ddl_pkg::FULL_SCALE);
  localparam logic signed [MW-1:0] MIX_MIN = -MW'(ddl_pkg::FULL_SCALE);
  localparam logic [PW-9:0] CAP = (PW-8)'(ddl_pkg::DELTA_CAP);

  logic [ddl_pkg::DECEL_W-1:0] decel_r;
  logic                        valid_r;
  ddl_pkg::stage_word_t        word_r;
  ddl_pkg::stage_word_t        word_nxt;

  logic signed [MW-1:0] sum;
  logic signed [MW-1:0] diff;
  logic        [PW-1:0] prod;
  logic                 accept;

  function automatic logic signed [ddl_pkg::LEVEL_W-1:0] clamp_fs(
    input logic signed [MW-1:0] x
  );
    logic signed [MW-1:0] r;
    if (x > MIX_MAX) begin
      r = MIX_MAX;
    end else if (x < MIX_MIN) begin
      r = MIX_MIN;
    end else begin
      r = x;
    end
    return r[ddl_pkg::LEVEL_W-1:0];
  endfunction

  assign sum  = MW'(in_forward) + MW'(in_turn);
  assign diff = MW'(in_forward) - MW'(in_turn);
  assign prod = PW'(in_elapsed_ms) * PW'(decel_r);

  always_comb begin
    word_nxt.cmd       = ddl_pkg::cmd_t'(in_command);
    word_nxt.left_mix  = clamp_fs(sum);
    word_nxt.right_mix = clamp_fs(diff);
    if (prod[PW-1:8] > CAP) begin
      word_nxt.delta = ddl_pkg::DELTA_W'(ddl_pkg::DELTA_CAP);
    end else begin
      word_nxt.delta = prod[8 +: ddl_pkg::DELTA_W];
    end
  end

  assign ctl.fire        = valid_r && (word_r.cmd == ddl_pkg::CMD_SET || slot_free);
  assign ctl.fire_update = ctl.fire && word_r.cmd == ddl_pkg::CMD_UPDATE;
  assign in_ready        = !valid_r || ctl.fire;
  assign accept          = in_valid && in_ready;
  assign word            = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decel_r <= ddl_pkg::DECEL_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        decel_r <= cfg_wdata;
      end
      if (accept) begin
        valid_r <= 1'b1;
      end else if (ctl.fire) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word_nxt;
    end
  end

  stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ctl.fire |=> valid_r && $stable(word_r))
    else $error("staged word lost or changed while stalled");

endmodule

>>> hdl/ddl_slew.sv
// Motor state: targets, applied levels and the deceleration limiter.
`timescale 1ns / 1ps

module ddl_slew (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ddl_pkg::stage_ctl_t                ctl,
  input  ddl_pkg::stage_word_t               word,
  output logic signed [ddl_pkg::LEVEL_W-1:0] left_nxt,
  output logic signed [ddl_pkg::LEVEL_W-1:0] right_nxt
);

  localparam int LW = ddl_pkg::LEVEL_W;
  localparam int AW = LW + 2;

  logic signed [LW-1:0] left_target_r;
  logic signed [LW-1:0] right_target_r;
  logic signed [LW-1:0] left_applied_r;
  logic signed [LW-1:0] right_applied_r;

  function automatic logic signed [LW-1:0] limit(
    input logic signed [LW-1:0]               app,
    input logic signed [LW-1:0]               tgt,
    input logic        [ddl_pkg::DELTA_W-1:0] dlt
  );
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] d;
    logic signed [AW-1:0] up;
    logic signed [AW-1:0] dn;
    logic signed [LW-1:0] r;
    a  = AW'(app);
    t  = AW'(tgt);
    d  = $signed(AW'(dlt));
    up = a + d;
    dn = a - d;
    // magnitude shrinking: step toward the target, never past it
    if (a > 0 && a > t) begin
      r = (dn > t) ? dn[LW-1:0] : tgt;
    end else if (a < 0 && a < t) begin
      r = (up < t) ? up[LW-1:0] : tgt;
    end else begin
      r = tgt;
    end
    return r;
  endfunction

  assign left_nxt  = limit(left_applied_r, left_target_r, word.delta);
  assign right_nxt = limit(right_applied_r, right_target_r, word.delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_target_r   <= '0;
      right_target_r  <= '0;
      left_applied_r  <= '0;
      right_applied_r <= '0;
    end else if (ctl.fire) begin
      if (word.cmd == ddl_pkg::CMD_SET) begin
        left_target_r  <= word.left_mix;
        right_target_r <= word.right_mix;
      end else begin
        left_applied_r  <= left_nxt;
        right_applied_r <= right_nxt;
      end
    end
  end

  left_decel_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire_update && left_applied_r > 0 && left_applied_r > left_target_r
    |=> left_applied_r <= $past(left_applied_r) && left_applied_r >= $past(left_target_r))
    else $error("left level overshot target while decelerating");

  left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_applied_r <= LW'(ddl_pkg::FULL_SCALE) && left_applied_r >= -LW'(ddl_pkg::FULL_SCALE))
    else $error("left level beyond full scale");

endmodule

>>> hdl/ddl_out.sv
// Duty conversion and result register.
`timescale 1ns / 1ps

module ddl_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ddl_pkg::stage_ctl_t                ctl,
  input  logic signed [ddl_pkg::LEVEL_W-1:0] left_lvl,
  input  logic signed [ddl_pkg::LEVEL_W-1:0] right_lvl,
  output logic                               slot_free,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [ddl_pkg::DUTY_W-1:0]  out_left_fwd_duty,
  output logic        [ddl_pkg::DUTY_W-1:0]  out_left_rev_duty,
  output logic        [ddl_pkg::DUTY_W-1:0]  out_right_fwd_duty,
  output logic        [ddl_pkg::DUTY_W-1:0]  out_right_rev_duty,
  output logic signed [ddl_pkg::LEVEL_W-1:0] out_left_level,
  output logic signed [ddl_pkg::LEVEL_W-1:0] out_right_level
);

  localparam int LW = ddl_pkg::LEVEL_W;
  localparam int DW = ddl_pkg::DUTY_W;
  localparam int QW = LW + ddl_pkg::DUTY_BITS;

  logic          valid_r;
  logic [DW-1:0] lf_r;
  logic [DW-1:0] lr_r;
  logic [DW-1:0] rf_r;
  logic [DW-1:0] rr_r;
  logic signed [LW-1:0] ll_r;
  logic signed [LW-1:0] rl_r;
  logic [DW-1:0] left_duty;
  logic [DW-1:0] right_duty;

  function automatic logic [DW-1:0] duty_of(input logic signed [LW-1:0] lvl);
    logic [LW-1:0] mag;
    logic [QW-1:0] q;
    mag = (lvl < 0) ? LW'(-lvl) : LW'(lvl);
    q   = QW'(mag) * QW'(ddl_pkg::DUTY_MAX);
    return q[ddl_pkg::FRACTION_BITS +: DW];
  endfunction

  assign left_duty  = duty_of(left_lvl);
  assign right_duty = duty_of(right_lvl);
  assign slot_free  = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.fire_update) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire_update) begin
      lf_r <= (left_lvl > 0) ? left_duty : '0;
      lr_r <= (left_lvl > 0) ? '0 : left_duty;
      rf_r <= (right_lvl > 0) ? right_duty : '0;
      rr_r <= (right_lvl > 0) ? '0 : right_duty;
      ll_r <= left_lvl;
      rl_r <= right_lvl;
    end
  end

  assign out_valid          = valid_r;
  assign out_left_fwd_duty  = lf_r;
  assign out_left_rev_duty  = lr_r;
  assign out_right_fwd_duty = rf_r;
  assign out_right_rev_duty = rr_r;
  assign out_left_level     = ll_r;
  assign out_right_level    = rl_r;

  update_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire_update |=> valid_r)
    else $error("update did not produce a result word");

  no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire_update |-> !valid_r || out_ready)
    else $error("pending result word overwritten");

  one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(lf_r != '0 && lr_r != '0) && !(rf_r != '0 && rr_r != '0))
    else $error("forward and reverse duty both driven");

endmodule

>>> hdl/differential_drive_decel_limiter.sv
// Top level of the two-motor differential drive with deceleration limiter.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid / in_ready        command, forward, turn, elapsed_ms
//   out      source     out_valid / out_ready      four duties, left/right level
//   cfg      sink       cfg_we (no wait)           decel_per_ms
//
// One word per cycle sustained while no held result stalls an update word;
// an update word's result is registered as the word leaves the stage register.
// The step-delta multiply sits ahead of the stage register, the limiter and
// duty math between it and the result register.
// Set words retire without a result; a held result stalls only update words.
// rst_n is synchronous; it clears the target and applied levels and loads the default decel rate.
`timescale 1ns / 1ps

module differential_drive_decel_limiter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [ddl_pkg::LEVEL_W-1:0]   in_forward,
  input  logic signed [ddl_pkg::LEVEL_W-1:0]   in_turn,
  input  logic        [ddl_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [ddl_pkg::DUTY_W-1:0]    out_left_fwd_duty,
  output logic        [ddl_pkg::DUTY_W-1:0]    out_left_rev_duty,
  output logic        [ddl_pkg::DUTY_W-1:0]    out_right_fwd_duty,
  output logic        [ddl_pkg::DUTY_W-1:0]    out_right_rev_duty,
  output logic signed [ddl_pkg::LEVEL_W-1:0]   out_left_level,
  output logic signed [ddl_pkg::LEVEL_W-1:0]   out_right_level,
  input  logic                                 cfg_we,
  input  logic        [ddl_pkg::DECEL_W-1:0]   cfg_wdata
);

  ddl_pkg::stage_ctl_t  ctl;
  ddl_pkg::stage_word_t word;
  logic                 slot_free;
  logic signed [ddl_pkg::LEVEL_W-1:0] left_nxt;
  logic signed [ddl_pkg::LEVEL_W-1:0] right_nxt;

  ddl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_forward    (in_forward),
    .in_turn       (in_turn),
    .in_elapsed_ms (in_elapsed_ms),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .slot_free     (slot_free),
    .ctl           (ctl),
    .word          (word)
  );

  ddl_slew u_slew (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .word      (word),
    .left_nxt  (left_nxt),
    .right_nxt (right_nxt)
  );

  ddl_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .left_lvl           (left_nxt),
    .right_lvl          (right_nxt),
    .slot_free          (slot_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_fwd_duty  (out_left_fwd_duty),
    .out_left_rev_duty  (out_left_rev_duty),
    .out_right_fwd_duty (out_right_fwd_duty),
    .out_right_rev_duty (out_right_rev_duty),
    .out_left_level     (out_left_level),
    .out_right_level    (out_right_level)
  );

endmodule
